// ----- design/irmfd_pkg.sv -----
// Package for the IR Manchester frame decoder.
// Holds field widths, register indexes, reset values and the decoder state type.
// No dependencies.
package irmfd_pkg;

  localparam int unsigned PRESCALE_BITS_DEF = 8;

  localparam int unsigned SILENCE_W = 10;
  localparam int unsigned SKIP_W    = 8;
  localparam int unsigned REPEAT_W  = 8;
  localparam int unsigned CMD_W     = 7;
  localparam int unsigned SHIFT_W   = 7;
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned WRAP_W    = 8;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_SKIP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_LIMIT  = 2'd2;

  localparam logic [SILENCE_W-1:0] SILENCE_RST = 10'd49;
  localparam logic [SKIP_W-1:0]    SKIP_RST    = 8'd16;
  localparam logic [REPEAT_W-1:0]  REPEAT_RST  = 8'd8;

  localparam logic [CMD_W-1:0]  NO_COMMAND = 7'd64;
  localparam logic [TICK_W-1:0] TICK_MAX   = 16'hFFFF;
  localparam logic [WRAP_W-1:0] WRAP_MAX   = 8'hFF;

  typedef enum logic [4:0] {
    ST_HUNT_RESTART = 5'b00001,
    ST_HUNT_SILENCE = 5'b00010,
    ST_HUNT_WAIT    = 5'b00100,
    ST_FRAME_EDGE   = 5'b01000,
    ST_FRAME_SKIP   = 5'b10000
  } state_t;

endpackage

// ----- design/irmfd_in_if.sv -----
// Input channel: one sampled receiver level per request.
// Depends on nothing.
interface irmfd_in_if;
  logic valid;
  logic ready;
  logic ir_level;

  modport source (output valid, output ir_level, input ready);
  modport sink   (input valid, input ir_level, output ready);
endinterface

// ----- design/irmfd_out_if.sv -----
// Result channel: current command code and frame completion flag.
// Depends on irmfd_pkg.
interface irmfd_out_if;
  logic                          valid;
  logic                          ready;
  logic [irmfd_pkg::CMD_W-1:0]   command;
  logic                          frame_done;

  modport source (output valid, output command, output frame_done, input ready);
  modport sink   (input valid, input command, input frame_done, output ready);
endinterface

// ----- design/irmfd_cfg_if.sv -----
// Configuration write channel: register index and write data.
// Depends on irmfd_pkg.
interface irmfd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [irmfd_pkg::CFG_IDX_W-1:0]   index;
  logic [irmfd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/ir_manchester_frame_decoder.sv -----
// IR Manchester frame decoder top level; uses irmfd_pkg and the channel interfaces.
// Latency: a result is presented the cycle after its input request is accepted.
// Throughput: one input request per cycle; the output register frees the input
// side whenever it is empty or being taken that cycle.
// Reset: synchronous active-low rst_n clears all decoder state, loads register
// defaults (49, 16, 8) and empties the output register; no clearing pass.
module ir_manchester_frame_decoder #(
  parameter int unsigned PRESCALE_BITS = irmfd_pkg::PRESCALE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  irmfd_in_if.sink           in_ch,
  irmfd_out_if.source        out_ch,
  irmfd_cfg_if.sink          cfg_ch
);

  logic [irmfd_pkg::SILENCE_W-1:0] silence_r;
  logic [irmfd_pkg::SKIP_W-1:0]    skip_r;
  logic [irmfd_pkg::REPEAT_W-1:0]  repeat_r;

  irmfd_pkg::state_t               state_r, state_nxt;
  logic                            prev_r, prev_nxt;
  logic [irmfd_pkg::SHIFT_W-1:0]   shift_r, shift_nxt;
  logic [irmfd_pkg::TICK_W-1:0]    tick_r, tick_nxt, tick_inc;
  logic [PRESCALE_BITS-1:0]        pre_r, pre_nxt;
  logic [irmfd_pkg::WRAP_W-1:0]    wrap_r, wrap_nxt, wrap_inc;
  logic [irmfd_pkg::CMD_W-1:0]     cmd_r, cmd_nxt;
  logic                            done_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [irmfd_pkg::CMD_W-1:0]     out_cmd_r;
  logic                            out_done_r;

  logic accept;
  logic lvl;
  logic [irmfd_pkg::TICK_W-1:0] silence_ext, skip_ext;
  logic [irmfd_pkg::WRAP_W-1:0] repeat_ext;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign lvl          = in_ch.ir_level;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.command    = out_cmd_r;
  assign out_ch.frame_done = out_done_r;

  assign silence_ext = irmfd_pkg::TICK_W'(silence_r);
  assign skip_ext    = irmfd_pkg::TICK_W'(skip_r);
  assign repeat_ext  = irmfd_pkg::WRAP_W'(repeat_r);

  always_comb begin
    tick_inc = (tick_r != irmfd_pkg::TICK_MAX) ? tick_r + 1'b1 : tick_r;
    pre_nxt  = pre_r + 1'b1;
    wrap_inc = (pre_nxt == '0 && wrap_r != irmfd_pkg::WRAP_MAX) ? wrap_r + 1'b1 : wrap_r;

    state_nxt = state_r;
    prev_nxt  = prev_r;
    shift_nxt = shift_r;
    tick_nxt  = tick_inc;
    wrap_nxt  = wrap_inc;
    cmd_nxt   = cmd_r;
    done_nxt  = 1'b0;

    case (state_r)
      irmfd_pkg::ST_HUNT_SILENCE: begin
        if (lvl == prev_r) begin
          if (tick_inc > silence_ext) begin
            state_nxt = irmfd_pkg::ST_HUNT_WAIT;
            wrap_nxt  = '0;
          end
        end else begin
          state_nxt = irmfd_pkg::ST_HUNT_RESTART;
        end
      end
      irmfd_pkg::ST_HUNT_WAIT: begin
        if (lvl != prev_r) begin
          state_nxt = irmfd_pkg::ST_FRAME_SKIP;
          tick_nxt  = '0;
          shift_nxt = '0;
        end else if (wrap_inc > repeat_ext) begin
          cmd_nxt = irmfd_pkg::NO_COMMAND;
        end
      end
      irmfd_pkg::ST_FRAME_SKIP: begin
        if (tick_inc > skip_ext) begin
          state_nxt = irmfd_pkg::ST_FRAME_EDGE;
          prev_nxt  = lvl;
          shift_nxt = {shift_r[irmfd_pkg::SHIFT_W-2:0], lvl};
        end
      end
      irmfd_pkg::ST_FRAME_EDGE: begin
        if (lvl != prev_r) begin
          prev_nxt  = lvl;
          state_nxt = irmfd_pkg::ST_FRAME_SKIP;
          tick_nxt  = '0;
        end else if (tick_inc > silence_ext) begin
          cmd_nxt   = {1'b0, ~shift_r[irmfd_pkg::SHIFT_W-1:1]};
          done_nxt  = 1'b1;
          state_nxt = irmfd_pkg::ST_HUNT_RESTART;
        end
      end
      default: begin
        tick_nxt  = '0;
        state_nxt = irmfd_pkg::ST_HUNT_SILENCE;
        prev_nxt  = lvl;
      end
    endcase
  end

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      silence_r <= irmfd_pkg::SILENCE_RST;
      skip_r    <= irmfd_pkg::SKIP_RST;
      repeat_r  <= irmfd_pkg::REPEAT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        irmfd_pkg::REG_SILENCE_LIMIT: silence_r <= cfg_ch.data;
        irmfd_pkg::REG_BIT_SKIP:      skip_r    <= cfg_ch.data[irmfd_pkg::SKIP_W-1:0];
        irmfd_pkg::REG_REPEAT_LIMIT:  repeat_r  <= cfg_ch.data[irmfd_pkg::REPEAT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= irmfd_pkg::ST_HUNT_RESTART;
      prev_r      <= 1'b0;
      shift_r     <= '0;
      tick_r      <= '0;
      pre_r       <= '0;
      wrap_r      <= '0;
      cmd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        state_r <= state_nxt;
        prev_r  <= prev_nxt;
        shift_r <= shift_nxt;
        tick_r  <= tick_nxt;
        pre_r   <= pre_nxt;
        wrap_r  <= wrap_nxt;
        cmd_r   <= cmd_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_cmd_r  <= cmd_nxt;
      out_done_r <= done_nxt;
    end
  end

endmodule

// ----- design/irmfd_checker.sv -----
// Port-level checker for the IR Manchester frame decoder, bound to the top level.
// Depends on irmfd_pkg and ir_manchester_frame_decoder.
module irmfd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [irmfd_pkg::CMD_W-1:0] out_command,
  input logic                        out_frame_done
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_command) && $stable(out_frame_done))
    else $error("result changed while stalled");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request produced no result");

  a_empty_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind ir_manchester_frame_decoder irmfd_checker u_irmfd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_command    (out_ch.command),
  .out_frame_done (out_ch.frame_done)
);
